@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the resampler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LIR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resampler assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LIR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resampler assertion failed");

`endif

@@ rtl/core/lir_pkg.sv @@
// Package: widths, constants and control types of the linear interpolation resampler.
package lir_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int SAMPLE_WIDTH = 16;
    localparam int PHASE_WIDTH  = FRAC_BITS + 5;
    localparam int PROD_WIDTH   = SAMPLE_WIDTH + FRAC_BITS + 2;

    localparam logic [PHASE_WIDTH-1:0] ONE_Q      = PHASE_WIDTH'(1) << FRAC_BITS;
    localparam logic [PHASE_WIDTH-1:0] STEP_MIN   = ONE_Q >> 4;
    localparam logic [PHASE_WIDTH-1:0] STEP_MAX   = ONE_Q << 4;
    localparam logic [PHASE_WIDTH-1:0] STEP_RESET = ONE_Q + (ONE_Q >> 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [PHASE_WIDTH-1:0]         phase_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic emit;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic phase_lt_one;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/core/linear_interp_resampler.sv @@
// Top level: linear interpolation sample rate converter.
// Flow: a taken input request goes to CHECK, then EMIT registers each output once there is room;
// a CHECK/EMIT loop over one multiplier gives N outputs per input, N from 0 to 16, and in_stall
// holds off the next input until the run finishes.
// Reset: asynchronous; step 1.5, phase, previous sample and primed flag cleared.
`include "assert_macros.svh"

module linear_interp_resampler (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [lir_pkg::PHASE_WIDTH-1:0]          cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [lir_pkg::SAMPLE_WIDTH-1:0]  in_sample,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [lir_pkg::SAMPLE_WIDTH-1:0]  out_sample,
    output logic                                     run_last
);
    import lir_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    lir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lir_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_sample  (in_sample),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample),
        .run_last   (run_last)
    );

    `LIR_ASSERT_NXT(a_busy_after_request, in_valid && !in_stall, in_stall)
    `LIR_ASSERT_IMP(a_emit_needs_room, cmd.emit, status.out_free)
    `LIR_ASSERT_NXT(a_mul_then_emit_wait, cmd.mul, !cmd.mul && !cmd.finish && !cmd.load)
    `LIR_ASSERT_IMP(a_load_only_when_idle, cmd.load, !in_stall && in_valid)

endmodule

@@ rtl/core/lir_ctrl.sv @@
// Controller: sequences the interpolation run of each input request.
module lir_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lir_pkg::dp_status_t status,
    output lir_pkg::dp_cmd_t    cmd
);
    import lir_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.phase_lt_one)
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/lir_datapath.sv @@
// Datapath: step register, phase accumulator, interpolation and output register.
module lir_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lir_pkg::PHASE_WIDTH-1:0]   cfg_data,
    input  logic signed [lir_pkg::SAMPLE_WIDTH-1:0] in_sample,
    input  lir_pkg::dp_cmd_t                  cmd,
    output lir_pkg::dp_status_t               status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [lir_pkg::SAMPLE_WIDTH-1:0] out_sample,
    output logic                              run_last
);
    import lir_pkg::*;

    localparam logic signed [SAMPLE_WIDTH+1:0] Y_MAX =
        {3'b000, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH+1:0] Y_MIN =
        {3'b111, {(SAMPLE_WIDTH-1){1'b0}}};

    phase_t  step_reg;
    phase_t  stepc_reg;
    phase_t  phase_reg;
    sample_t prev_reg;
    sample_t cur_reg;
    logic    primed_reg;
    logic    out_valid_reg;
    sample_t out_sample_reg;
    logic    run_last_reg;
    logic signed [PROD_WIDTH-1:0] prod_reg;

    phase_t                          step_clamped;
    phase_t                          phase_sum;
    logic signed [SAMPLE_WIDTH:0]    diff;
    logic signed [FRAC_BITS:0]       phase_frac;
    logic signed [PROD_WIDTH-1:0]    prod_next;
    logic signed [SAMPLE_WIDTH+1:0]  y_sum;
    sample_t                         y_sat;
    sample_t                         y_out;

    always_comb
    begin
        priority if (step_reg < STEP_MIN)
        begin
            step_clamped = STEP_MIN;
        end
        else if (step_reg > STEP_MAX)
        begin
            step_clamped = STEP_MAX;
        end
        else
        begin
            step_clamped = step_reg;
        end
    end

    assign phase_sum  = phase_reg + stepc_reg;
    assign diff       = $signed({cur_reg[SAMPLE_WIDTH-1], cur_reg})
                      - $signed({prev_reg[SAMPLE_WIDTH-1], prev_reg});
    assign phase_frac = $signed({1'b0, phase_reg[FRAC_BITS-1:0]});
    assign prod_next  = PROD_WIDTH'(diff) * PROD_WIDTH'(phase_frac);

    // floor of product / 2^FRAC_BITS is the arithmetic shift
    assign y_sum = $signed({{2{prev_reg[SAMPLE_WIDTH-1]}}, prev_reg})
                 + $signed(prod_reg[PROD_WIDTH-1:FRAC_BITS]);

    always_comb
    begin
        priority if (y_sum > Y_MAX)
        begin
            y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (y_sum < Y_MIN)
        begin
            y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y_sat = y_sum[SAMPLE_WIDTH-1:0];
        end
    end

    assign y_out = primed_reg ? y_sat : cur_reg;

    assign status.phase_lt_one = (phase_reg < ONE_Q);
    assign status.out_free     = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RESET;
            phase_reg     <= '0;
            prev_reg      <= '0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                step_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                phase_reg     <= phase_sum;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                phase_reg  <= phase_reg - ONE_Q;
                prev_reg   <= cur_reg;
                primed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg   <= in_sample;
            stepc_reg <= step_clamped;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.emit)
        begin
            out_sample_reg <= y_out;
            run_last_reg   <= (phase_sum >= ONE_Q);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign run_last   = run_last_reg;

endmodule

@@ tb/sv/linear_interp_resampler_test.sv @@
// Testbench for linear_interp_resampler: random and directed samples checked against a predictor.
`timescale 1ns / 1ps

typedef struct packed {
    lir_pkg::sample_t value;
    logic             last;
} resampled_t;

class resample_scoreboard;
    lir_pkg::phase_t  step_reg;
    lir_pkg::phase_t  phase;
    lir_pkg::sample_t prev_value;
    bit               primed;
    resampled_t       expected_q[$];
    int               errors;
    int               requests_seen;
    int               results_seen;
    int               silent_requests;

    function new();
        step_reg        = lir_pkg::STEP_RESET;
        phase           = '0;
        prev_value      = '0;
        primed          = 1'b0;
        errors          = 0;
        requests_seen   = 0;
        results_seen    = 0;
        silent_requests = 0;
    endfunction

    function void set_step(lir_pkg::phase_t value);
        step_reg = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void add_expected(resampled_t r);
        expected_q = {expected_q, r};
    endfunction

    task report_mismatch(string msg);
        if (errors < 30)
            $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // one accepted input request -> its run of interpolated outputs
    function void note_request(lir_pkg::sample_t cur);
        longint     step_eff;
        longint     diff;
        longint     y;
        int         n;
        resampled_t r;
        requests_seen++;
        step_eff = longint'(step_reg);
        if (step_eff < longint'(lir_pkg::STEP_MIN))
            step_eff = longint'(lir_pkg::STEP_MIN);
        if (step_eff > longint'(lir_pkg::STEP_MAX))
            step_eff = longint'(lir_pkg::STEP_MAX);
        n = 0;
        while (phase < lir_pkg::ONE_Q && n < 16)
        begin
            if (primed)
            begin
                diff = longint'(cur) - longint'(prev_value);
                y = longint'(prev_value) + ((diff * longint'(phase)) >>> lir_pkg::FRAC_BITS);
                if (y > 32767)
                    y = 32767;
                if (y < -32768)
                    y = -32768;
            end
            else
            begin
                y = longint'(cur);
            end
            r.value = lir_pkg::sample_t'(y);
            r.last  = 1'b0;
            add_expected(r);
            n++;
            phase = phase + lir_pkg::phase_t'(step_eff);
        end
        if (n > 0)
        begin
            r.last = 1'b1;
            expected_q[expected_q.size() - 1] = r;
        end
        else
        begin
            silent_requests++;
        end
        phase      = phase - lir_pkg::ONE_Q;
        prev_value = cur;
        primed     = 1'b1;
    endfunction

    task check_result(lir_pkg::sample_t got, logic last);
        resampled_t e;
        results_seen++;
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected output sample %0d last %b", got, last));
            return;
        end
        e = expected_q.pop_front();
        if (got !== e.value)
            report_mismatch($sformatf("out_sample %0d, predicted %0d", got, e.value));
        if (last !== e.last)
            report_mismatch($sformatf("run_last %b, predicted %b", last, e.last));
    endtask

    task flush_leftovers();
        resampled_t e;
        while (expected_q.size() != 0)
        begin
            e = expected_q.pop_front();
            report_mismatch($sformatf("output %0d last %b never arrived", e.value, e.last));
        end
    endtask
endclass

module linear_interp_resampler_test;
    import lir_pkg::*;

    localparam int      RANDOM_ITEMS = 400;
    localparam int      DRAIN_CYCLES = 40;
    localparam int      QUIET_LIMIT  = 4000;
    localparam int      HOLD_CYCLES  = 300;
    localparam sample_t SMP_HI       = 16'sh7fff;
    localparam sample_t SMP_LO       = 16'sh8000;

    logic    clk;
    logic    rst_n;
    logic    cfg_write;
    phase_t  cfg_data;
    logic    in_valid;
    logic    in_stall;
    sample_t in_sample;
    logic    out_valid;
    logic    out_stall;
    sample_t out_sample;
    logic    run_last;

    resample_scoreboard sb = new();

    bit steady;
    int hold_requests;
    int hold_served;
    int hold_left;
    int quiet_cycles;
    int ramp_value;
    int step_writes;

    linear_interp_resampler uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_sample  (in_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample),
        .run_last   (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(0, 99) < 25);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_sample, run_last);
            if (in_valid && !in_stall)
                sb.note_request(in_sample);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic sample_t next_sample();
        int      v;
        int      delta;
        sample_t s;
        case ($urandom_range(0, 9))
            0:
            begin
                v = $urandom_range(0, 1) ? 32767 : -32768;
            end
            1, 2, 3, 4:
            begin
                s = sample_t'($urandom);
                v = s;
            end
            default:
            begin
                delta = $urandom_range(0, 1024);
                v = ramp_value + delta - 512;
            end
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        ramp_value = v;
        return sample_t'(v);
    endfunction

    function automatic phase_t random_step();
        phase_t s;
        case ($urandom_range(0, 7))
            0: s = STEP_MIN;
            1: s = STEP_MAX;
            2: s = ONE_Q;
            3: s = phase_t'($urandom_range(0, STEP_MIN - 1));
            4: s = phase_t'($urandom_range(STEP_MAX + 1, (1 << PHASE_WIDTH) - 1));
            default: s = phase_t'($urandom_range(STEP_MIN, 3 * ONE_Q));
        endcase
        return s;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(input sample_t value);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 25)
            gap = $urandom_range(1, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_step(input phase_t value);
        drain_block();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.set_step(value);
        step_writes++;
    endtask

    initial
    begin
        int phase_no;
        int batch;
        int random_sent;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_sample     = '0;
        out_stall     = 1'b0;
        steady        = 1'b0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        ramp_value    = 0;
        step_writes   = 0;
        phase_no      = 0;
        random_sent   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset step 1.5, first request passes through unprimed
        send_sample(SMP_HI);
        send_sample(SMP_LO);
        send_sample(SMP_HI);
        send_sample(-1);
        send_sample(0);
        send_sample(SMP_LO);
        send_sample(12345);
        // zero step, clamped up to 1/16: a shorter first run, then full 16-output runs across the extremes
        write_step('0);
        send_sample(SMP_LO);
        send_sample(SMP_HI);
        send_sample(-100);
        // all ones, clamped down to 16.0: mostly empty runs
        write_step('1);
        repeat (6) send_sample(next_sample());
        write_step(STEP_MAX);
        send_sample(SMP_HI);
        send_sample(SMP_LO);
        send_sample(0);
        send_sample(-1);
        write_step(STEP_MIN);
        send_sample(SMP_HI);
        send_sample(-1);
        send_sample(SMP_LO);

        while (random_sent < RANDOM_ITEMS)
        begin
            if (phase_no == 1)
            begin
                // smallest step while the receiver holds off: block backs up
                write_step(STEP_MIN);
                hold_requests++;
                batch = 30;
            end
            else
            begin
                write_step(random_step());
                batch = (phase_no == 3) ? 60 : $urandom_range(20, 50);
            end
            steady = (phase_no == 3);
            for (int k = 0; k < batch && random_sent < RANDOM_ITEMS; k++)
            begin
                if (phase_no == 5 && k == batch / 2)
                    drain_block();
                send_sample(next_sample());
                random_sent++;
            end
            steady = 1'b0;
            phase_no++;
        end

        drain_block();
        sb.flush_leftovers();
        $display("covered %0d input requests and %0d output results over %0d step writes",
                 sb.requests_seen, sb.results_seen, step_writes);
        $display("%0d requests gave no output; receiver hold-off and drained pause included",
                 sb.silent_requests);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/lir_pkg.sv
rtl/core/lir_ctrl.sv
rtl/core/lir_datapath.sv
rtl/core/linear_interp_resampler.sv
tb/sv/linear_interp_resampler_test.sv
